[design/pci_pkg.sv]
// ============================================================================
// pci_pkg
// Shared types, widths and codes for the polygon centroid and inertia block.
// ============================================================================
`default_nettype none

package pci_pkg;

    localparam int MAX_VERTS = 32;
    localparam int COORD_W   = 16;
    localparam int IDX_W     = $clog2(MAX_VERTS);
    localparam int CNT_W     = $clog2(MAX_VERTS + 1);

    // edge term px*qy - py*qx, and the sums built from it
    localparam int T_W       = 2 * COORD_W + 1;
    localparam int T_LO_W    = COORD_W;
    localparam int AREA_W    = T_W + IDX_W;
    localparam int CS_W      = T_W + COORD_W + IDX_W;
    localparam int BR_W      = 2 * COORD_W + 3;
    localparam int ACC_W     = 64;

    // shared signed multiplier
    localparam int MUL_A_W   = BR_W;
    localparam int MUL_B_W   = COORD_W + 2;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int PR_W      = BR_W + T_W;

    // shared divider
    localparam int DIV_W       = ACC_W;
    localparam int DCNT_W      = $clog2(CS_W + 1);
    localparam int RATIO_BITS  = 32;
    localparam int CLAMP_SHIFT = 40;
    localparam int CTR_W       = CLAMP_SHIFT + 2;

    localparam logic [1:0] STATUS_OK          = 2'd0;
    localparam logic [1:0] STATUS_ZERO_AREA   = 2'd1;
    localparam logic [1:0] STATUS_ZERO_MOMENT = 2'd2;
    localparam logic [1:0] STATUS_OVERFLOW    = 2'd3;

    // sequencer steps, centroid pass
    localparam logic [3:0] P0_PXQY = 4'd0;
    localparam logic [3:0] P0_PYQX = 4'd1;
    localparam logic [3:0] P0_CX   = 4'd2;
    localparam logic [3:0] P0_CY   = 4'd3;
    // sequencer steps, moment pass
    localparam logic [3:0] P1_BR_X  = 4'd0;
    localparam logic [3:0] P1_BR_XX = 4'd1;
    localparam logic [3:0] P1_BR_Y  = 4'd2;
    localparam logic [3:0] P1_BR_YY = 4'd3;
    localparam logic [3:0] P1_PXQY  = 4'd4;
    localparam logic [3:0] P1_PYQX  = 4'd5;
    localparam logic [3:0] P1_PR_LO = 4'd6;
    localparam logic [3:0] P1_PR_HI = 4'd7;
    localparam logic [3:0] P1_MOM   = 4'd8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD0_WAIT,
        S_RDQ,
        S_RDQ_WAIT,
        S_MAC,
        S_CHECK_AREA,
        S_DIV,
        S_DIV_END,
        S_CHECK_MOMENT,
        S_EMIT_RD,
        S_EMIT_LOAD,
        S_EMIT_WAIT,
        S_SUM_LOAD,
        S_SUM_WAIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_CTR_X,
        DIV_CTR_Y,
        DIV_RATIO
    } div_sel_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [CTR_W:0] v);
        logic signed [COORD_W-1:0] r;
        r = v[COORD_W-1:0];
        if (!v[CTR_W] && (|v[CTR_W-1:COORD_W-1]))
            r = {1'b0, {(COORD_W-1){1'b1}}};
        else if (v[CTR_W] && !(&v[CTR_W-1:COORD_W-1]))
            r = {1'b1, {(COORD_W-1){1'b0}}};
        return r;
    endfunction

endpackage

`default_nettype wire

[design/pci_ram.sv]
// ============================================================================
// pci_ram
// Generic single write port, single read port RAM with registered read data.
// ============================================================================
`default_nettype none

module pci_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/polygon_centroid_inertia.sv]
// ============================================================================
// polygon_centroid_inertia
// Centroid and polar moment of a closed polygon, vertices re-centered.
// ============================================================================
// Input channel (in_valid/in_ready): one vertex per transaction, Q12.4, with
// last_vertex on the final one. Up to MAX_VERTS vertices are kept in a
// RAM; extra ones are dropped and flagged. On the final vertex a sequencer
// drives one shared 35x18 signed multiplier through a centroid pass, then a
// moment pass, over the edges; one shared restoring divider (one quotient
// bit per cycle) gives each centroid coordinate and area over moment; a ratio
// that saturates or has a sign mismatch skips the ratio division.
// Output channel (out_valid/out_ready): n centered vertices in input order,
// then one summary transaction with last_result set; an error run gives the
// summary alone. A stalled receiver holds the output register and the
// sequencer waits on it. in_ready is high only while no polygon is in work.
// Reset clears the sums, the vertex count and the sequencer; the vertex RAM
// is not cleared.
// ============================================================================
`default_nettype none

module polygon_centroid_inertia (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [pci_pkg::COORD_W-1:0]   vertex_x,
    input  wire logic signed [pci_pkg::COORD_W-1:0]   vertex_y,
    input  wire logic                                 last_vertex,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic signed [pci_pkg::COORD_W-1:0]        centered_x,
    output logic signed [pci_pkg::COORD_W-1:0]        centered_y,
    output logic [31:0]                               inv_inertia,
    output logic                                      is_summary,
    output logic [1:0]                                status,
    output logic                                      last_result
);

    localparam int CW = pci_pkg::COORD_W;

    pci_pkg::state_t   state_reg, state_next;
    pci_pkg::div_sel_t div_sel_reg, div_sel_next;

    logic [pci_pkg::CNT_W-1:0]          count_reg, count_next;
    logic                               overflow_reg, overflow_next;
    logic signed [pci_pkg::AREA_W-1:0]  area_reg, area_next;
    logic signed [pci_pkg::CS_W-1:0]    cxs_reg, cxs_next;
    logic signed [pci_pkg::CS_W-1:0]    cys_reg, cys_next;
    logic signed [pci_pkg::ACC_W-1:0]   mom_reg, mom_next;
    logic                               pass_reg, pass_next;
    logic [3:0]                         step_reg, step_next;
    logic [pci_pkg::IDX_W-1:0]          idx_reg, idx_next;
    logic [1:0]                         status_reg, status_next;
    logic [31:0]                        inv_reg, inv_next;
    logic                               out_valid_reg, out_valid_next;

    logic signed [CW-1:0]               px_reg, px_next, py_reg, py_next;
    logic signed [CW-1:0]               qx_reg, qx_next, qy_reg, qy_next;
    logic signed [pci_pkg::T_W-1:0]     t_reg, t_next;
    logic signed [pci_pkg::BR_W-1:0]    br_reg, br_next;
    logic signed [pci_pkg::PR_W-1:0]    pr_reg, pr_next;
    logic signed [pci_pkg::CTR_W-1:0]   ctrx_reg, ctrx_next, ctry_reg, ctry_next;
    logic [pci_pkg::DIV_W-1:0]          div_rem_reg, div_rem_next;
    logic [pci_pkg::DIV_W-1:0]          div_den_reg, div_den_next;
    logic [pci_pkg::CS_W-1:0]           div_num_reg, div_num_next;
    logic [pci_pkg::CS_W-1:0]           div_quo_reg, div_quo_next;
    logic [pci_pkg::DCNT_W-1:0]         div_cnt_reg, div_cnt_next;
    logic                               div_neg_reg, div_neg_next;
    logic signed [CW-1:0]               ox_reg, ox_next, oy_reg, oy_next;
    logic [31:0]                        oinv_reg, oinv_next;
    logic                               osum_reg, osum_next;
    logic [1:0]                         ostat_reg, ostat_next;
    logic                               olast_reg, olast_next;

    logic                               in_acc, out_acc;
    logic                               ram_we;
    logic [pci_pkg::IDX_W-1:0]          ram_raddr;
    logic [2*CW-1:0]                    ram_rdata;
    logic signed [CW-1:0]               ram_x, ram_y, cen_x, cen_y, ld_x, ld_y;
    logic [pci_pkg::CNT_W-1:0]          idx_plus;
    logic                               last_idx;
    logic [pci_pkg::IDX_W-1:0]          nidx;
    logic signed [CW:0]                 sum_x, sum_y;
    logic signed [pci_pkg::MUL_A_W-1:0] mul_a;
    logic signed [pci_pkg::MUL_B_W-1:0] mul_b;
    logic signed [pci_pkg::PROD_W-1:0]  prod;
    logic [pci_pkg::AREA_W-1:0]         mag_area;
    logic [pci_pkg::CS_W-1:0]           mag_cxs, mag_cys;
    logic [pci_pkg::DIV_W-1:0]          mag_mom, den3, area6;
    logic [pci_pkg::DIV_W:0]            rem2, rem_diff;
    logic                               div_ge, div_rnd;
    logic [pci_pkg::CS_W:0]             q_round, clamp_q;
    logic [pci_pkg::CLAMP_SHIFT:0]      q_clamp;
    logic signed [pci_pkg::CTR_W-1:0]   ctr_res;
    logic [31:0]                        ratio_res;
    logic signed [pci_pkg::ACC_W-1:0]   pr_sat;
    logic [pci_pkg::ACC_W:0]            mom_sum;
    logic signed [pci_pkg::ACC_W-1:0]   mom_add;

    assign in_ready  = (state_reg == pci_pkg::S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_acc   = out_valid_reg && out_ready;

    assign centered_x  = ox_reg;
    assign centered_y  = oy_reg;
    assign inv_inertia = oinv_reg;
    assign is_summary  = osum_reg;
    assign status      = ostat_reg;
    assign last_result = olast_reg;

    // vertex store: x in the low half, y in the high half
    assign ram_we = in_acc && (count_reg < pci_pkg::CNT_W'(pci_pkg::MAX_VERTS));

    pci_ram #(
        .WIDTH (2 * CW),
        .DEPTH (pci_pkg::MAX_VERTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[pci_pkg::IDX_W-1:0]),
        .wdata ({vertex_y, vertex_x}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_plus = pci_pkg::CNT_W'(idx_reg) + pci_pkg::CNT_W'(1);
    assign last_idx = (idx_plus == count_reg);
    assign nidx     = last_idx ? '0 : idx_plus[pci_pkg::IDX_W-1:0];

    always_comb
    begin
        case (state_reg)
            pci_pkg::S_RD0: ram_raddr = '0;
            pci_pkg::S_RDQ: ram_raddr = nidx;
            default:        ram_raddr = idx_reg;
        endcase
    end

    assign ram_x = ram_rdata[CW-1:0];
    assign ram_y = ram_rdata[2*CW-1:CW];
    assign cen_x = pci_pkg::sat_coord((pci_pkg::CTR_W+1)'(ram_x) -
                                      (pci_pkg::CTR_W+1)'(ctrx_reg));
    assign cen_y = pci_pkg::sat_coord((pci_pkg::CTR_W+1)'(ram_y) -
                                      (pci_pkg::CTR_W+1)'(ctry_reg));
    // moment pass works on centered coordinates
    assign ld_x = pass_reg ? cen_x : ram_x;
    assign ld_y = pass_reg ? cen_y : ram_y;

    assign sum_x = (CW+1)'(px_reg) + (CW+1)'(qx_reg);
    assign sum_y = (CW+1)'(py_reg) + (CW+1)'(qy_reg);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (!pass_reg)
        begin
            case (step_reg)
                pci_pkg::P0_PXQY:
                begin
                    mul_a = pci_pkg::MUL_A_W'(px_reg);
                    mul_b = pci_pkg::MUL_B_W'(qy_reg);
                end
                pci_pkg::P0_PYQX:
                begin
                    mul_a = pci_pkg::MUL_A_W'(py_reg);
                    mul_b = pci_pkg::MUL_B_W'(qx_reg);
                end
                pci_pkg::P0_CX:
                begin
                    mul_a = pci_pkg::MUL_A_W'(t_reg);
                    mul_b = pci_pkg::MUL_B_W'(sum_x);
                end
                pci_pkg::P0_CY:
                begin
                    mul_a = pci_pkg::MUL_A_W'(t_reg);
                    mul_b = pci_pkg::MUL_B_W'(sum_y);
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
        else
        begin
            case (step_reg)
                pci_pkg::P1_BR_X:
                begin
                    mul_a = pci_pkg::MUL_A_W'(px_reg);
                    mul_b = pci_pkg::MUL_B_W'(sum_x);
                end
                pci_pkg::P1_BR_XX:
                begin
                    mul_a = pci_pkg::MUL_A_W'(qx_reg);
                    mul_b = pci_pkg::MUL_B_W'(qx_reg);
                end
                pci_pkg::P1_BR_Y:
                begin
                    mul_a = pci_pkg::MUL_A_W'(py_reg);
                    mul_b = pci_pkg::MUL_B_W'(sum_y);
                end
                pci_pkg::P1_BR_YY:
                begin
                    mul_a = pci_pkg::MUL_A_W'(qy_reg);
                    mul_b = pci_pkg::MUL_B_W'(qy_reg);
                end
                pci_pkg::P1_PXQY:
                begin
                    mul_a = pci_pkg::MUL_A_W'(px_reg);
                    mul_b = pci_pkg::MUL_B_W'(qy_reg);
                end
                pci_pkg::P1_PYQX:
                begin
                    mul_a = pci_pkg::MUL_A_W'(py_reg);
                    mul_b = pci_pkg::MUL_B_W'(qx_reg);
                end
                pci_pkg::P1_PR_LO:
                begin
                    mul_a = br_reg;
                    mul_b = $signed({2'b00, t_reg[pci_pkg::T_LO_W-1:0]});
                end
                pci_pkg::P1_PR_HI:
                begin
                    mul_a = br_reg;
                    mul_b = pci_pkg::MUL_B_W'($signed(t_reg[pci_pkg::T_W-1:pci_pkg::T_LO_W]));
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign prod = mul_a * mul_b;

    // magnitudes for the divider
    assign mag_area = area_reg[pci_pkg::AREA_W-1] ? pci_pkg::AREA_W'(-area_reg)
                                                  : pci_pkg::AREA_W'(area_reg);
    assign mag_cxs  = cxs_reg[pci_pkg::CS_W-1] ? pci_pkg::CS_W'(-cxs_reg)
                                               : pci_pkg::CS_W'(cxs_reg);
    assign mag_cys  = cys_reg[pci_pkg::CS_W-1] ? pci_pkg::CS_W'(-cys_reg)
                                               : pci_pkg::CS_W'(cys_reg);
    assign mag_mom  = mom_reg[pci_pkg::ACC_W-1] ? pci_pkg::DIV_W'(-mom_reg)
                                                : pci_pkg::DIV_W'(mom_reg);
    assign den3  = pci_pkg::DIV_W'(mag_area) + pci_pkg::DIV_W'({mag_area, 1'b0});
    assign area6 = pci_pkg::DIV_W'({mag_area, 2'b00}) + pci_pkg::DIV_W'({mag_area, 1'b0});

    // one restoring step
    assign rem2     = {div_rem_reg, div_num_reg[pci_pkg::CS_W-1]};
    assign rem_diff = rem2 - {1'b0, div_den_reg};
    assign div_ge   = (rem2 >= {1'b0, div_den_reg});

    // round half up on the remainder, then clamp
    assign div_rnd = ({div_rem_reg, 1'b0} >= {1'b0, div_den_reg});
    assign q_round = {1'b0, div_quo_reg} + (pci_pkg::CS_W+1)'(div_rnd);
    assign clamp_q = {{(pci_pkg::CS_W-pci_pkg::CLAMP_SHIFT){1'b0}}, 1'b1,
                      {pci_pkg::CLAMP_SHIFT{1'b0}}};
    assign q_clamp = (q_round > clamp_q) ? clamp_q[pci_pkg::CLAMP_SHIFT:0]
                                         : q_round[pci_pkg::CLAMP_SHIFT:0];
    assign ctr_res = div_neg_reg ? -$signed({1'b0, q_clamp}) : $signed({1'b0, q_clamp});
    assign ratio_res = (q_round > (pci_pkg::CS_W+1)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                     : q_round[31:0];

    // saturate the 68-bit product, then saturating accumulate
    always_comb
    begin
        if ((&pr_reg[pci_pkg::PR_W-1:pci_pkg::ACC_W-1]) ||
            !(|pr_reg[pci_pkg::PR_W-1:pci_pkg::ACC_W-1]))
            pr_sat = pr_reg[pci_pkg::ACC_W-1:0];
        else if (pr_reg[pci_pkg::PR_W-1])
            pr_sat = {1'b1, {(pci_pkg::ACC_W-1){1'b0}}};
        else
            pr_sat = {1'b0, {(pci_pkg::ACC_W-1){1'b1}}};
    end

    assign mom_sum = {mom_reg[pci_pkg::ACC_W-1], mom_reg} + {pr_sat[pci_pkg::ACC_W-1], pr_sat};

    always_comb
    begin
        if (mom_sum[pci_pkg::ACC_W] == mom_sum[pci_pkg::ACC_W-1])
            mom_add = mom_sum[pci_pkg::ACC_W-1:0];
        else if (mom_sum[pci_pkg::ACC_W])
            mom_add = {1'b1, {(pci_pkg::ACC_W-1){1'b0}}};
        else
            mom_add = {1'b0, {(pci_pkg::ACC_W-1){1'b1}}};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pci_pkg::S_IDLE:
                if (in_acc && last_vertex)
                    state_next = pci_pkg::S_RD0;
            pci_pkg::S_RD0:      state_next = pci_pkg::S_RD0_WAIT;
            pci_pkg::S_RD0_WAIT: state_next = pci_pkg::S_RDQ;
            pci_pkg::S_RDQ:      state_next = pci_pkg::S_RDQ_WAIT;
            pci_pkg::S_RDQ_WAIT: state_next = pci_pkg::S_MAC;
            pci_pkg::S_MAC:
            begin
                if ((!pass_reg && step_reg == pci_pkg::P0_CY) ||
                    (pass_reg && step_reg == pci_pkg::P1_MOM))
                begin
                    if (!last_idx)
                        state_next = pci_pkg::S_RDQ;
                    else if (!pass_reg)
                        state_next = pci_pkg::S_CHECK_AREA;
                    else
                        state_next = pci_pkg::S_CHECK_MOMENT;
                end
            end
            pci_pkg::S_CHECK_AREA:
                if (overflow_reg || area_reg == '0)
                    state_next = pci_pkg::S_SUM_LOAD;
                else
                    state_next = pci_pkg::S_DIV;
            pci_pkg::S_DIV:
                if (div_cnt_reg == pci_pkg::DCNT_W'(1))
                    state_next = pci_pkg::S_DIV_END;
            pci_pkg::S_DIV_END:
            begin
                case (div_sel_reg)
                    pci_pkg::DIV_CTR_X: state_next = pci_pkg::S_DIV;
                    pci_pkg::DIV_CTR_Y: state_next = pci_pkg::S_RD0;
                    default:            state_next = pci_pkg::S_EMIT_RD;
                endcase
            end
            pci_pkg::S_CHECK_MOMENT:
                if (mom_reg == '0)
                    state_next = pci_pkg::S_SUM_LOAD;
                else if ((area_reg[pci_pkg::AREA_W-1] != mom_reg[pci_pkg::ACC_W-1]) ||
                         (area6 >= mag_mom))
                    state_next = pci_pkg::S_EMIT_RD;
                else
                    state_next = pci_pkg::S_DIV;
            pci_pkg::S_EMIT_RD:   state_next = pci_pkg::S_EMIT_LOAD;
            pci_pkg::S_EMIT_LOAD: state_next = pci_pkg::S_EMIT_WAIT;
            pci_pkg::S_EMIT_WAIT:
                if (out_acc)
                    state_next = last_idx ? pci_pkg::S_SUM_LOAD : pci_pkg::S_EMIT_RD;
            pci_pkg::S_SUM_LOAD:  state_next = pci_pkg::S_SUM_WAIT;
            pci_pkg::S_SUM_WAIT:
                if (out_acc)
                    state_next = pci_pkg::S_IDLE;
            default: state_next = pci_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        count_next     = count_reg;
        overflow_next  = overflow_reg;
        area_next      = area_reg;
        cxs_next       = cxs_reg;
        cys_next       = cys_reg;
        mom_next       = mom_reg;
        pass_next      = pass_reg;
        step_next      = step_reg;
        idx_next       = idx_reg;
        status_next    = status_reg;
        inv_next       = inv_reg;
        out_valid_next = out_valid_reg;
        div_sel_next   = div_sel_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        t_next         = t_reg;
        br_next        = br_reg;
        pr_next        = pr_reg;
        ctrx_next      = ctrx_reg;
        ctry_next      = ctry_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_num_next   = div_num_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        div_neg_next   = div_neg_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        oinv_next      = oinv_reg;
        osum_next      = osum_reg;
        ostat_next     = ostat_reg;
        olast_next     = olast_reg;

        case (state_reg)
            pci_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (ram_we)
                        count_next = count_reg + pci_pkg::CNT_W'(1);
                    else
                        overflow_next = 1'b1;
                    if (last_vertex)
                    begin
                        pass_next = 1'b0;
                        idx_next  = '0;
                    end
                end
            end
            pci_pkg::S_RD0_WAIT:
            begin
                px_next = ld_x;
                py_next = ld_y;
            end
            pci_pkg::S_RDQ_WAIT:
            begin
                qx_next   = ld_x;
                qy_next   = ld_y;
                step_next = '0;
            end
            pci_pkg::S_MAC:
            begin
                step_next = step_reg + 4'd1;
                if (!pass_reg)
                begin
                    case (step_reg)
                        pci_pkg::P0_PXQY: t_next = pci_pkg::T_W'(prod);
                        pci_pkg::P0_PYQX: t_next = t_reg - pci_pkg::T_W'(prod);
                        pci_pkg::P0_CX:
                        begin
                            cxs_next  = cxs_reg + pci_pkg::CS_W'(prod);
                            area_next = area_reg + pci_pkg::AREA_W'(t_reg);
                        end
                        pci_pkg::P0_CY:
                        begin
                            cys_next = cys_reg + pci_pkg::CS_W'(prod);
                            px_next  = qx_reg;
                            py_next  = qy_reg;
                            idx_next = nidx;
                        end
                        default: t_next = t_reg;
                    endcase
                end
                else
                begin
                    case (step_reg)
                        pci_pkg::P1_BR_X:  br_next = pci_pkg::BR_W'(prod);
                        pci_pkg::P1_BR_XX: br_next = br_reg + pci_pkg::BR_W'(prod);
                        pci_pkg::P1_BR_Y:  br_next = br_reg + pci_pkg::BR_W'(prod);
                        pci_pkg::P1_BR_YY: br_next = br_reg + pci_pkg::BR_W'(prod);
                        pci_pkg::P1_PXQY:  t_next  = pci_pkg::T_W'(prod);
                        pci_pkg::P1_PYQX:  t_next  = t_reg - pci_pkg::T_W'(prod);
                        pci_pkg::P1_PR_LO: pr_next = pci_pkg::PR_W'(prod);
                        pci_pkg::P1_PR_HI:
                            pr_next = pr_reg + (pci_pkg::PR_W'(prod) <<< pci_pkg::T_LO_W);
                        pci_pkg::P1_MOM:
                        begin
                            mom_next = mom_add;
                            px_next  = qx_reg;
                            py_next  = qy_reg;
                            idx_next = nidx;
                        end
                        default: br_next = br_reg;
                    endcase
                end
            end
            pci_pkg::S_CHECK_AREA:
            begin
                if (overflow_reg)
                    status_next = pci_pkg::STATUS_OVERFLOW;
                else if (area_reg == '0)
                    status_next = pci_pkg::STATUS_ZERO_AREA;
                else
                begin
                    div_sel_next = pci_pkg::DIV_CTR_X;
                    div_rem_next = '0;
                    div_num_next = mag_cxs;
                    div_den_next = den3;
                    div_quo_next = '0;
                    div_cnt_next = pci_pkg::DCNT_W'(pci_pkg::CS_W);
                    div_neg_next = cxs_reg[pci_pkg::CS_W-1] ^ area_reg[pci_pkg::AREA_W-1];
                end
            end
            pci_pkg::S_DIV:
            begin
                div_rem_next = div_ge ? rem_diff[pci_pkg::DIV_W-1:0] : rem2[pci_pkg::DIV_W-1:0];
                div_num_next = {div_num_reg[pci_pkg::CS_W-2:0], 1'b0};
                div_quo_next = {div_quo_reg[pci_pkg::CS_W-2:0], div_ge};
                div_cnt_next = div_cnt_reg - pci_pkg::DCNT_W'(1);
            end
            pci_pkg::S_DIV_END:
            begin
                case (div_sel_reg)
                    pci_pkg::DIV_CTR_X:
                    begin
                        ctrx_next    = ctr_res;
                        div_sel_next = pci_pkg::DIV_CTR_Y;
                        div_rem_next = '0;
                        div_num_next = mag_cys;
                        div_den_next = den3;
                        div_quo_next = '0;
                        div_cnt_next = pci_pkg::DCNT_W'(pci_pkg::CS_W);
                        div_neg_next = cys_reg[pci_pkg::CS_W-1] ^ area_reg[pci_pkg::AREA_W-1];
                    end
                    pci_pkg::DIV_CTR_Y:
                    begin
                        ctry_next = ctr_res;
                        pass_next = 1'b1;
                        idx_next  = '0;
                    end
                    default:
                    begin
                        inv_next = ratio_res;
                        idx_next = '0;
                    end
                endcase
            end
            pci_pkg::S_CHECK_MOMENT:
            begin
                idx_next = '0;
                if (mom_reg == '0)
                    status_next = pci_pkg::STATUS_ZERO_MOMENT;
                else if (area_reg[pci_pkg::AREA_W-1] != mom_reg[pci_pkg::ACC_W-1])
                    inv_next = '0;
                else if (area6 >= mag_mom)
                    inv_next = 32'hFFFF_FFFF;
                else
                begin
                    // area over moment: remainder starts at 6*area, zeros shift in
                    div_sel_next = pci_pkg::DIV_RATIO;
                    div_rem_next = area6;
                    div_num_next = '0;
                    div_den_next = mag_mom;
                    div_quo_next = '0;
                    div_cnt_next = pci_pkg::DCNT_W'(pci_pkg::RATIO_BITS);
                    div_neg_next = 1'b0;
                end
            end
            pci_pkg::S_EMIT_LOAD:
            begin
                ox_next        = cen_x;
                oy_next        = cen_y;
                oinv_next      = '0;
                osum_next      = 1'b0;
                ostat_next     = pci_pkg::STATUS_OK;
                olast_next     = 1'b0;
                out_valid_next = 1'b1;
            end
            pci_pkg::S_EMIT_WAIT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    if (!last_idx)
                        idx_next = idx_plus[pci_pkg::IDX_W-1:0];
                end
            end
            pci_pkg::S_SUM_LOAD:
            begin
                ox_next        = '0;
                oy_next        = '0;
                oinv_next      = inv_reg;
                osum_next      = 1'b1;
                ostat_next     = status_reg;
                olast_next     = 1'b1;
                out_valid_next = 1'b1;
            end
            pci_pkg::S_SUM_WAIT:
            begin
                if (out_acc)
                begin
                    // drop the run, back to reset values
                    out_valid_next = 1'b0;
                    count_next     = '0;
                    overflow_next  = 1'b0;
                    area_next      = '0;
                    cxs_next       = '0;
                    cys_next       = '0;
                    mom_next       = '0;
                    status_next    = pci_pkg::STATUS_OK;
                    inv_next       = '0;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pci_pkg::S_IDLE;
            div_sel_reg   <= pci_pkg::DIV_CTR_X;
            count_reg     <= '0;
            overflow_reg  <= 1'b0;
            area_reg      <= '0;
            cxs_reg       <= '0;
            cys_reg       <= '0;
            mom_reg       <= '0;
            pass_reg      <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
            status_reg    <= pci_pkg::STATUS_OK;
            inv_reg       <= '0;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            div_sel_reg   <= div_sel_next;
            count_reg     <= count_next;
            overflow_reg  <= overflow_next;
            area_reg      <= area_next;
            cxs_reg       <= cxs_next;
            cys_reg       <= cys_next;
            mom_reg       <= mom_next;
            pass_reg      <= pass_next;
            step_reg      <= step_next;
            idx_reg       <= idx_next;
            status_reg    <= status_next;
            inv_reg       <= inv_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        qx_reg      <= qx_next;
        qy_reg      <= qy_next;
        t_reg       <= t_next;
        br_reg      <= br_next;
        pr_reg      <= pr_next;
        ctrx_reg    <= ctrx_next;
        ctry_reg    <= ctry_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_num_reg <= div_num_next;
        div_quo_reg <= div_quo_next;
        div_neg_reg <= div_neg_next;
        ox_reg      <= ox_next;
        oy_reg      <= oy_next;
        oinv_reg    <= oinv_next;
        osum_reg    <= osum_next;
        ostat_reg   <= ostat_next;
        olast_reg   <= olast_next;
    end

    a_no_input_while_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid_reg)
        else $error("input taken while a result is pending");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pci_pkg::CNT_W'(pci_pkg::MAX_VERTS))
        else $error("vertex count past store depth");

    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && osum_reg) |-> (olast_reg && ox_reg == '0 && oy_reg == '0))
        else $error("summary transaction malformed");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pci_pkg::S_DIV) |-> (div_cnt_reg != '0))
        else $error("divider running with no steps left");

    a_clear_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == pci_pkg::S_SUM_WAIT && out_acc) |=>
            (count_reg == '0 && !overflow_reg && mom_reg == '0))
        else $error("run state not cleared after summary");

endmodule

`default_nettype wire
